FILE: rtl/core/msp_pkg.sv
// Shared types and constants for the MSP v1 frame parser.
// Used by msp_step and msp_v1_frame_parser; no dependencies.
package msp_pkg;

    localparam logic [7:0] CH_START        = 8'h24;
    localparam logic [7:0] CH_M            = 8'h4D;
    localparam logic [7:0] CH_CMD          = 8'h3C;
    localparam logic [7:0] CH_REPLY        = 8'h3E;
    localparam logic [7:0] MAX_PAYLOAD_RST = 8'd192;

    typedef enum logic [5:0] {
        PH_IDLE     = 6'b000001,
        PH_START    = 6'b000010,
        PH_M        = 6'b000100,
        PH_HEADER   = 6'b001000,
        PH_PAYLOAD  = 6'b010000,
        PH_CHECKSUM = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_GOOD   = 2'd1,
        EV_BADSUM = 2'd2,
        EV_TOOBIG = 2'd3
    } event_t;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] byte_count;
        logic [7:0] frame_length;
        logic [7:0] frame_command;
        logic [7:0] running_xor;
        logic       reply_flag;
    } state_t;

    typedef struct packed {
        logic       consumed;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        event_t     frame_event;
        logic       is_reply;
        logic [7:0] command;
        logic [7:0] payload_length;
    } result_t;

endpackage

FILE: rtl/core/msp_v1_frame_parser.sv
// Top level of the MSP v1 frame parser: input register, parser state, result register.
// Depends on msp_pkg and msp_step.
//
// Takes one received byte per transfer and returns exactly one result per byte. A byte
// passes through an input register and then a result register, from which its result
// is presented on the m_* outputs. One byte per cycle is sustained while the result
// side takes results. The parser state advances when a byte moves from the input
// register into the result register; a stalled result holds both stages. Payload bytes
// are reported as they arrive and are good only once a good-frame event follows. Write
// cfg_wr_en/cfg_wr_data only while no byte is in flight.
module msp_v1_frame_parser (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_consumed,
    output logic       m_payload_valid,
    output logic [7:0] m_payload_byte,
    output logic [7:0] m_payload_index,
    output logic [1:0] m_frame_event,
    output logic       m_is_reply,
    output logic [7:0] m_command,
    output logic [7:0] m_payload_length
);
    import msp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic [7:0] max_payload_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    step_res;
    logic       advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    msp_step u_step (
        .state_cur  (state_reg),
        .rx_byte    (in_byte_reg),
        .max_payload(max_payload_reg),
        .state_nxt  (state_next),
        .res        (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_wr_en) begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_IDLE;
            state_reg.byte_count    <= 8'd0;
            state_reg.frame_length  <= 8'd0;
            state_reg.frame_command <= 8'd0;
            state_reg.running_xor   <= 8'd0;
            state_reg.reply_flag    <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_consumed       = out_reg.consumed;
    assign m_payload_valid  = out_reg.payload_valid;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_payload_index  = out_reg.payload_index;
    assign m_frame_event    = out_reg.frame_event;
    assign m_is_reply       = out_reg.is_reply;
    assign m_command        = out_reg.command;
    assign m_payload_length = out_reg.payload_length;

`ifndef SYNTHESIS
    a_payload_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_PAYLOAD |-> state_reg.byte_count < state_reg.frame_length)
        else $error("payload byte count reached frame length while in payload phase");

    a_payload_len_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_PAYLOAD |-> state_reg.frame_length != 8'd0)
        else $error("payload phase entered with an empty frame length");

    a_index_below_length: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.payload_valid |->
            (out_reg.payload_index < out_reg.payload_length && out_reg.frame_event == EV_NONE))
        else $error("payload result inconsistent with its frame header");

    a_event_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_res.frame_event != EV_NONE |=> state_reg.phase == PH_IDLE)
        else $error("parser not idle after a frame event");
`endif

endmodule

FILE: rtl/core/msp_step.sv
// Next-state and result logic for one received byte of the MSP v1 parser.
// Depends on msp_pkg.
module msp_step (
    input  msp_pkg::state_t  state_cur,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       max_payload,
    output msp_pkg::state_t  state_nxt,
    output msp_pkg::result_t res
);
    import msp_pkg::*;

    logic [7:0] cnt_inc;
    logic [7:0] xor_nxt;

    assign cnt_inc = state_cur.byte_count + 8'd1;
    assign xor_nxt = state_cur.running_xor ^ rx_byte;

    always_comb begin
        state_nxt = state_cur;
        res = '0;
        res.consumed = 1'b1;
        res.frame_event = EV_NONE;

        case (state_cur.phase)
            PH_START: begin
                state_nxt.byte_count = 8'd0;
                state_nxt.running_xor = 8'd0;
                state_nxt.phase = (rx_byte == CH_M) ? PH_M : PH_IDLE;
            end
            PH_M: begin
                if (rx_byte == CH_CMD) begin
                    state_nxt.reply_flag = 1'b0;
                    state_nxt.phase = PH_HEADER;
                end else if (rx_byte == CH_REPLY) begin
                    state_nxt.reply_flag = 1'b1;
                    state_nxt.phase = PH_HEADER;
                end else begin
                    state_nxt.phase = PH_IDLE;
                end
            end
            PH_HEADER: begin
                state_nxt.running_xor = xor_nxt;
                if (state_cur.byte_count == 8'd0) begin
                    state_nxt.frame_length = rx_byte;
                    state_nxt.byte_count = 8'd1;
                end else begin
                    state_nxt.frame_command = rx_byte;
                    state_nxt.byte_count = 8'd0;
                    if (state_cur.frame_length > max_payload) begin
                        res.frame_event = EV_TOOBIG;
                        state_nxt.phase = PH_IDLE;
                    end else if (state_cur.frame_length != 8'd0) begin
                        state_nxt.phase = PH_PAYLOAD;
                    end else begin
                        state_nxt.phase = PH_CHECKSUM;
                    end
                end
            end
            PH_PAYLOAD: begin
                state_nxt.running_xor = xor_nxt;
                res.payload_valid = 1'b1;
                res.payload_byte = rx_byte;
                res.payload_index = state_cur.byte_count;
                state_nxt.byte_count = cnt_inc;
                if (cnt_inc == state_cur.frame_length) begin
                    state_nxt.phase = PH_CHECKSUM;
                end
            end
            PH_CHECKSUM: begin
                res.frame_event = (state_cur.running_xor == rx_byte) ? EV_GOOD : EV_BADSUM;
                state_nxt.phase = PH_IDLE;
            end
            default: begin
                if (rx_byte == CH_START) begin
                    state_nxt.phase = PH_START;
                end else begin
                    state_nxt.phase = PH_IDLE;
                    res.consumed = 1'b0;
                end
            end
        endcase

        res.is_reply = state_nxt.reply_flag;
        res.command = state_nxt.frame_command;
        res.payload_length = state_nxt.frame_length;
    end

endmodule

FILE: verif/msp_v1_frame_parser_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for msp_v1_frame_parser: streams directed and random MSP v1
// traffic through the valid/ready channels and checks every result against a byte-level
// parser model kept in a scoreboard class. Depends on msp_pkg and the parser RTL.
module msp_v1_frame_parser_test;
    import msp_pkg::*;

    class msp_frame_tracker;
        logic [7:0] max_payload;
        phase_t     phase;
        logic [7:0] byte_count;
        logic [7:0] frame_length;
        logic [7:0] frame_command;
        logic [7:0] running_xor;
        logic       reply_flag;
        result_t    expected_results[$];
        int         fail_count;

        function new();
            max_payload   = MAX_PAYLOAD_RST;
            phase         = PH_IDLE;
            byte_count    = '0;
            frame_length  = '0;
            frame_command = '0;
            running_xor   = '0;
            reply_flag    = 1'b0;
            fail_count    = 0;
        endfunction

        function void report(string msg);
            fail_count++;
            if (fail_count <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        function void compare_field(string name, int want, int seen);
            if (want != seen) begin
                report($sformatf("%s expected %0h actual %0h", name, want, seen));
            end
        endfunction

        function void note_rx_byte(logic [7:0] c);
            result_t r;
            r = '0;
            r.consumed = 1'b1;
            r.frame_event = EV_NONE;
            case (phase)
                PH_START: begin
                    byte_count  = '0;
                    running_xor = '0;
                    phase = (c == CH_M) ? PH_M : PH_IDLE;
                end
                PH_M: begin
                    if (c == CH_CMD) begin
                        reply_flag = 1'b0;
                        phase = PH_HEADER;
                    end else if (c == CH_REPLY) begin
                        reply_flag = 1'b1;
                        phase = PH_HEADER;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
                PH_HEADER: begin
                    running_xor ^= c;
                    if (byte_count == 8'd0) begin
                        frame_length = c;
                        byte_count = 8'd1;
                    end else begin
                        frame_command = c;
                        byte_count = 8'd0;
                        if (frame_length > max_payload) begin
                            r.frame_event = EV_TOOBIG;
                            phase = PH_IDLE;
                        end else begin
                            phase = (frame_length != 8'd0) ? PH_PAYLOAD : PH_CHECKSUM;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    running_xor ^= c;
                    r.payload_valid = 1'b1;
                    r.payload_byte  = c;
                    r.payload_index = byte_count;
                    byte_count = byte_count + 8'd1;
                    if (byte_count == frame_length) begin
                        phase = PH_CHECKSUM;
                    end
                end
                PH_CHECKSUM: begin
                    r.frame_event = (running_xor == c) ? EV_GOOD : EV_BADSUM;
                    phase = PH_IDLE;
                end
                default: begin
                    if (c == CH_START) begin
                        phase = PH_START;
                    end else begin
                        r.consumed = 1'b0;
                    end
                end
            endcase
            r.is_reply       = reply_flag;
            r.command        = frame_command;
            r.payload_length = frame_length;
            expected_results.push_back(r);
        endfunction

        function void check_result(result_t seen);
            result_t want;
            if (expected_results.size() == 0) begin
                report("result transfer with no byte outstanding");
                return;
            end
            want = expected_results.pop_front();
            compare_field("consumed", want.consumed, seen.consumed);
            compare_field("payload_valid", want.payload_valid, seen.payload_valid);
            compare_field("payload_byte", want.payload_byte, seen.payload_byte);
            compare_field("payload_index", want.payload_index, seen.payload_index);
            compare_field("frame_event", want.frame_event, seen.frame_event);
            compare_field("is_reply", want.is_reply, seen.is_reply);
            compare_field("command", want.command, seen.command);
            compare_field("payload_length", want.payload_length, seen.payload_length);
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_consumed;
    logic       m_payload_valid;
    logic [7:0] m_payload_byte;
    logic [7:0] m_payload_index;
    logic [1:0] m_frame_event;
    logic       m_is_reply;
    logic [7:0] m_command;
    logic [7:0] m_payload_length;

    msp_frame_tracker tracker = new();
    logic [7:0]       rx_plan[$];
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    msp_v1_frame_parser dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_consumed       (m_consumed),
        .m_payload_valid  (m_payload_valid),
        .m_payload_byte   (m_payload_byte),
        .m_payload_index  (m_payload_index),
        .m_frame_event    (m_frame_event),
        .m_is_reply       (m_is_reply),
        .m_command        (m_command),
        .m_payload_length (m_payload_length)
    );

    always #5 aclk = ~aclk;

    initial begin
        forever begin
            @(negedge aclk);
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        result_t seen;
        if (aresetn && m_valid && m_ready) begin
            seen.consumed       = m_consumed;
            seen.payload_valid  = m_payload_valid;
            seen.payload_byte   = m_payload_byte;
            seen.payload_index  = m_payload_index;
            seen.frame_event    = event_t'(m_frame_event);
            seen.is_reply       = m_is_reply;
            seen.command        = m_command;
            seen.payload_length = m_payload_length;
            tracker.check_result(seen);
        end
    end

    initial begin
        #5_000_000;
        $display("FAIL msp_v1_frame_parser");
        $finish;
    end

    function automatic void add_frame(bit reply, logic [7:0] size, logic [7:0] cmd,
                                      bit bad_sum, logic [7:0] limit);
        logic [7:0] sum;
        logic [7:0] data;
        rx_plan.push_back(CH_START);
        rx_plan.push_back(CH_M);
        rx_plan.push_back(reply ? CH_REPLY : CH_CMD);
        rx_plan.push_back(size);
        rx_plan.push_back(cmd);
        sum = size ^ cmd;
        if (size > limit) begin
            return;
        end
        for (int i = 0; i < size; i++) begin
            data = 8'($urandom);
            rx_plan.push_back(data);
            sum ^= data;
        end
        rx_plan.push_back(bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
    endfunction

    function automatic void add_random_traffic(int quota, logic [7:0] limit);
        int         target;
        int         pick;
        int         small_cap;
        logic [7:0] size;
        target = rx_plan.size() + quota;
        small_cap = (limit < 12) ? limit : 12;
        while (rx_plan.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 3)) rx_plan.push_back(8'($urandom));
            end else if (pick < 20) begin
                case ($urandom_range(2))
                    0: begin
                        rx_plan.push_back(CH_START);
                        rx_plan.push_back(8'($urandom));
                    end
                    1: begin
                        rx_plan.push_back(CH_START);
                        rx_plan.push_back(CH_M);
                        rx_plan.push_back(8'($urandom));
                    end
                    default: begin
                        size = 8'($urandom_range(0, small_cap));
                        rx_plan.push_back(CH_START);
                        rx_plan.push_back(CH_M);
                        rx_plan.push_back($urandom_range(1) ? CH_REPLY : CH_CMD);
                        rx_plan.push_back(size);
                        rx_plan.push_back(8'($urandom));
                        repeat ($urandom_range(0, size)) rx_plan.push_back(8'($urandom));
                    end
                endcase
            end else begin
                pick = $urandom_range(99);
                if (pick < 85) begin
                    size = 8'($urandom_range(0, small_cap));
                end else if (pick < 90 || limit == 8'd255) begin
                    size = limit;
                end else begin
                    size = 8'($urandom_range(limit + 1, 255));
                end
                add_frame(1'($urandom_range(1)), size, 8'($urandom),
                          $urandom_range(99) < 15, limit);
            end
        end
    endfunction

    task automatic wait_drained();
        while (tracker.expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic start_phase(logic [7:0] limit, int send_pct, int recv_pct);
        wait_drained();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        tracker.max_payload = limit;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        rx_plan.delete();
    endtask

    task automatic send_plan();
        foreach (rx_plan[i]) begin
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            s_valid   <= 1'b1;
            s_rx_byte <= rx_plan[i];
            do @(posedge aclk); while (!s_ready);
            tracker.note_rx_byte(rx_plan[i]);
        end
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] mid_limit;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // header boundaries, bad second and direction bytes, zero size, bad sum, oversize
        start_phase(8'd192, 0, 0);
        rx_plan = '{8'h00, 8'hFF,
                    CH_START, CH_M, CH_CMD, 8'h00, 8'h7F, 8'h7F,
                    CH_START, 8'h4E,
                    CH_START, CH_M, 8'h21,
                    CH_START, CH_M, CH_REPLY, 8'h02, 8'h80, 8'hA5, 8'h5A, 8'h00,
                    CH_START, CH_M, CH_CMD, 8'd193, 8'h01};
        add_random_traffic(70, 8'd192);
        send_plan();

        start_phase(8'd0, 60, 0);
        add_random_traffic(70, 8'd0);
        send_plan();

        start_phase(8'd255, 0, 60);
        add_frame(1'b0, 8'd255, 8'($urandom), 1'b0, 8'd255);
        add_random_traffic(70, 8'd255);
        send_plan();

        mid_limit = 8'($urandom_range(1, 254));
        start_phase(mid_limit, 30, 30);
        add_random_traffic(70, mid_limit);
        send_plan();

        start_phase(8'd8, 0, 0);
        add_random_traffic(70, 8'd8);
        send_plan();

        wait_drained();
        if (tracker.expected_results.size() != 0) begin
            tracker.report("results still outstanding at end of run");
        end
        if (tracker.fail_count == 0) begin
            $display("PASS msp_v1_frame_parser");
        end else begin
            $display("FAIL msp_v1_frame_parser");
        end
        $finish;
    end

endmodule
